@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: property does not hold");

`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

@@ src/rti_pkg.sv @@
package rti_pkg;

  localparam int CMD_W        = 2;
  localparam int REGION_W     = 7;
  localparam int IN_AREA_W    = 20;
  localparam int OUT_W        = 26;
  localparam int LEAF_COUNT_W = 7;

  localparam int DEF_MAX_LEAVES  = 64;
  localparam int DEF_MAX_REGIONS = 128;
  localparam int DEF_AREA_BITS   = 20;

  // areas per row of the area memory
  localparam int LEAF_LANES = 4;
  localparam int LANE_AW    = 2;

  localparam logic [LEAF_COUNT_W-1:0] LEAF_COUNT_RESET = 7'd64;
  localparam logic [OUT_W-1:0]        OUT_MAX          = '1;

  localparam logic [CMD_W-1:0] CMD_RESTART  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_AREA = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MERGE    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd3;

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_LEAF_COUNT = 1'b0;

  typedef struct packed {
    logic                 en;
    logic [REGION_W-1:0]  idx;
    logic [IN_AREA_W-1:0] data;
  } area_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sum_status_t;

endpackage

@@ src/rti_if.sv @@
interface rti_item_if import rti_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [REGION_W-1:0]  region_a;
  logic [REGION_W-1:0]  region_b;
  logic [IN_AREA_W-1:0] area;

  modport source (output valid, cmd, region_a, region_b, area, input ready);
  modport sink (input valid, cmd, region_a, region_b, area, output ready);
endinterface

interface rti_result_if import rti_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] intersection_area;

  modport source (output valid, intersection_area, input ready);
  modport sink (input valid, intersection_area, output ready);
endinterface

@@ src/region_tree_intersection_area_core.sv @@
// Region tree intersection area. Each region of a merge tree holds a leaf
// bitmask in a two-read, one-write mask memory; leaf areas sit in a second
// memory laid out four areas to a row. A set-area command writes its area when
// accepted, and a merge reads both masks, then writes their OR back. During a
// query the area memory supplies one row of four areas per cycle to the
// accumulator. A restart, and the reset itself, rebuild every mask in a pass
// of one entry per cycle, during which no item is accepted; a restart samples
// the leaf count when the pass starts, the reset pass uses MAX_LEAVES. Only a
// query returns a transaction; a finished result may wait in the output
// register while the next item is taken. leaf_count is at byte address 0 of
// the APB port.
`include "assert_macros.svh"

module region_tree_intersection_area_core import rti_pkg::*; #(
  parameter int MAX_LEAVES  = DEF_MAX_LEAVES,
  parameter int MAX_REGIONS = DEF_MAX_REGIONS,
  parameter int AREA_BITS   = DEF_AREA_BITS
) (
  input  logic               clk,
  input  logic               rst,
  rti_item_if.sink           item,
  rti_result_if.source       result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int REG_AW  = $clog2(MAX_REGIONS);
  localparam int LCNT_W  = $clog2(MAX_LEAVES + 1);
  localparam int STATE_W = 3;

  localparam logic [STATE_W-1:0] S_SWEEP = 3'd0;
  localparam logic [STATE_W-1:0] S_IDLE  = 3'd1;
  localparam logic [STATE_W-1:0] S_MERGE = 3'd2;
  localparam logic [STATE_W-1:0] S_QMASK = 3'd3;
  localparam logic [STATE_W-1:0] S_QSUM  = 3'd4;
  localparam logic [STATE_W-1:0] S_QOUT  = 3'd5;

  logic [STATE_W-1:0]      state;
  logic [REG_AW-1:0]       sweep_cnt;
  logic [LCNT_W-1:0]       sweep_n;
  logic                    sweep_last;
  logic [LEAF_COUNT_W-1:0] leaf_count;
  logic [LCNT_W-1:0]       eff_n;
  logic                    cfg_we;

  logic                    in_accept;
  logic                    ra_ok;
  logic                    rb_ok;
  logic                    both_leaves;
  logic                    q_zero;
  logic                    merge_ok;
  logic [REG_AW-1:0]       merge_addr;

  logic [REG_AW-1:0]       rd_addr_a;
  logic [REG_AW-1:0]       rd_addr_b;
  logic [MAX_LEAVES-1:0]   mask_rd_a;
  logic [MAX_LEAVES-1:0]   mask_rd_b;
  logic                    mask_we;
  logic [REG_AW-1:0]       mask_waddr;
  logic [MAX_LEAVES-1:0]   mask_wdata;

  area_wr_t                area_wr;
  logic                    sum_start;
  logic [MAX_LEAVES-1:0]   common;
  sum_status_t             sum_st;
  logic [OUT_W-1:0]        sum_out;

  logic                    out_valid;
  logic [OUT_W-1:0]        out_data;

  // configuration
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_LEAF_COUNT) ? PDATA_W'(leaf_count) : '0;
  assign eff_n  = (leaf_count > LEAF_COUNT_W'(MAX_LEAVES)) ? LCNT_W'(MAX_LEAVES)
                                                           : LCNT_W'(leaf_count);

  // input side
  assign item.ready  = (state == S_IDLE);
  assign in_accept   = item.valid && item.ready;
  assign ra_ok       = (32'(item.region_a) < MAX_REGIONS);
  assign rb_ok       = (32'(item.region_b) < MAX_REGIONS);
  assign both_leaves = (32'(item.region_a) < 32'(eff_n)) && (32'(item.region_b) < 32'(eff_n));
  assign rd_addr_a   = REG_AW'(item.region_a);
  assign rd_addr_b   = REG_AW'(item.region_b);

  assign area_wr.en   = in_accept && (item.cmd == CMD_SET_AREA);
  assign area_wr.idx  = item.region_a;
  assign area_wr.data = item.area;

  // mask write port: restart pass or merge write-back
  assign sweep_last = (32'(sweep_cnt) == MAX_REGIONS - 1);
  always_comb begin
    mask_we    = 1'b0;
    mask_waddr = merge_addr;
    mask_wdata = mask_rd_a | mask_rd_b;
    case (state)
      S_SWEEP: begin
        mask_we    = 1'b1;
        mask_waddr = sweep_cnt;
        mask_wdata = (32'(sweep_cnt) < 32'(sweep_n)) ? (MAX_LEAVES'(1) << sweep_cnt) : '0;
      end
      S_MERGE: begin
        mask_we = merge_ok;
      end
      default: begin
        mask_we = 1'b0;
      end
    endcase
  end

  assign sum_start = (state == S_QMASK);
  assign common    = q_zero ? '0 : (mask_rd_a & mask_rd_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_cnt  <= '0;
      sweep_n    <= LCNT_W'(MAX_LEAVES);
      leaf_count <= LEAF_COUNT_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we && (paddr[PADDR_W-1:2] == REG_LEAF_COUNT)) begin
        leaf_count <= pwdata[LEAF_COUNT_W-1:0];
      end
      if ((state == S_QOUT) && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          sweep_cnt <= REG_AW'(sweep_cnt + 1'b1);
          if (sweep_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            case (item.cmd)
              CMD_RESTART: begin
                sweep_cnt <= '0;
                sweep_n   <= eff_n;
                state     <= S_SWEEP;
              end
              CMD_MERGE: state <= S_MERGE;
              CMD_QUERY: state <= S_QMASK;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_MERGE: state <= S_IDLE;
        S_QMASK: state <= S_QSUM;
        S_QSUM: begin
          if (sum_st.done) begin
            state <= S_QOUT;
          end
        end
        S_QOUT: begin
          if (!out_valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      q_zero     <= (item.region_a == item.region_b) || both_leaves || !ra_ok || !rb_ok;
      merge_ok   <= ra_ok && rb_ok;
      merge_addr <= rd_addr_a;
    end
    if ((state == S_QOUT) && (!out_valid || result.ready)) begin
      out_data <= sum_out;
    end
  end

  assign result.valid             = out_valid;
  assign result.intersection_area = out_data;

  rti_mask_mem #(
    .DEPTH (MAX_REGIONS),
    .WIDTH (MAX_LEAVES)
  ) u_mask_mem (
    .clk       (clk),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (mask_rd_a),
    .rd_data_b (mask_rd_b),
    .we        (mask_we),
    .wr_addr   (mask_waddr),
    .wr_data   (mask_wdata)
  );

  rti_area_sum #(
    .MAX_LEAVES (MAX_LEAVES),
    .AREA_BITS  (AREA_BITS)
  ) u_area_sum (
    .clk    (clk),
    .rst    (rst),
    .wr     (area_wr),
    .start  (sum_start),
    .mask   (common),
    .status (sum_st),
    .sum    (sum_out)
  );

  `ASSERT_PROP(a_merge_after_accept, clk, rst, (state == S_MERGE) |-> $past(in_accept && (item.cmd == CMD_MERGE)))
  `ASSERT_PROP(a_result_from_qout, clk, rst, $rose(out_valid) |-> $past(state == S_QOUT))
  `ASSERT_NEVER(a_done_outside_qsum, clk, rst, sum_st.done && (state != S_QSUM))
  `ASSERT_PROP(a_qsum_has_work, clk, rst, (state == S_QSUM) |-> (sum_st.busy || sum_st.done))
  `ASSERT_PROP(a_sweep_ends_idle, clk, rst, ((state == S_SWEEP) && sweep_last) |=> (state == S_IDLE))

endmodule

@@ src/rti_mask_mem.sv @@
module rti_mask_mem import rti_pkg::*; #(
  parameter int DEPTH = DEF_MAX_REGIONS,
  parameter int WIDTH = DEF_MAX_LEAVES
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

@@ src/rti_area_sum.sv @@
module rti_area_sum import rti_pkg::*; #(
  parameter int MAX_LEAVES = DEF_MAX_LEAVES,
  parameter int AREA_BITS  = DEF_AREA_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  area_wr_t              wr,
  input  logic                  start,
  input  logic [MAX_LEAVES-1:0] mask,
  output sum_status_t           status,
  output logic [OUT_W-1:0]      sum
);

  localparam int ROWS   = (MAX_LEAVES + LEAF_LANES - 1) / LEAF_LANES;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PAD_W  = ROWS * LEAF_LANES;
  localparam int SUM_W  = AREA_BITS + $clog2(MAX_LEAVES) + 1;
  localparam int EXT_W  = (SUM_W > OUT_W) ? SUM_W : OUT_W;

  logic [LEAF_LANES-1:0][AREA_BITS-1:0] area_mem [ROWS];
  logic [LEAF_LANES-1:0][AREA_BITS-1:0] rd_row;

  logic                  wr_ok;
  logic [ROW_AW-1:0]     wr_row;
  logic [LANE_AW-1:0]    wr_lane;
  logic [PAD_W-1:0]      mask_sh;
  logic [LEAF_LANES-1:0] rd_lanes;
  logic [ROW_AW-1:0]     row_cnt;
  logic                  row_last;
  logic                  issuing;
  logic                  pend;
  logic                  done_q;
  logic [SUM_W-1:0]      acc;
  logic [SUM_W-1:0]      row_sum;
  logic [EXT_W-1:0]      acc_ext;

  assign wr_ok    = wr.en && (32'(wr.idx) < MAX_LEAVES);
  assign wr_row   = ROW_AW'(wr.idx >> LANE_AW);
  assign wr_lane  = wr.idx[LANE_AW-1:0];
  assign row_last = (32'(row_cnt) == ROWS - 1);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      area_mem[wr_row][wr_lane] <= AREA_BITS'(wr.data);
    end
  end

  always_ff @(posedge clk) begin
    rd_row <= area_mem[row_cnt];
  end

  always_comb begin
    row_sum = '0;
    for (int l = 0; l < LEAF_LANES; l++) begin
      if (rd_lanes[l]) begin
        row_sum = row_sum + SUM_W'(rd_row[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      pend    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      pend   <= issuing;
      done_q <= pend && !issuing;
      if (start) begin
        issuing <= 1'b1;
      end else if (issuing && row_last) begin
        issuing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mask_sh <= PAD_W'(mask);
      row_cnt <= '0;
      acc     <= '0;
    end else begin
      if (issuing) begin
        rd_lanes <= mask_sh[LEAF_LANES-1:0];
        mask_sh  <= mask_sh >> LEAF_LANES;
        row_cnt  <= ROW_AW'(row_cnt + 1'b1);
      end
      if (pend) begin
        acc <= acc + row_sum;
      end
    end
  end

  assign acc_ext     = EXT_W'(acc);
  assign sum         = (acc_ext > EXT_W'(OUT_MAX)) ? OUT_MAX : acc_ext[OUT_W-1:0];
  assign status.busy = issuing || pend;
  assign status.done = done_q;

endmodule
